>>> rtl/length_preserving_vector_rejection_macros.svh
// Assertion macros used by the vector rejection RTL.
`ifndef LENGTH_PRESERVING_VECTOR_REJECTION_MACROS_SVH
`define LENGTH_PRESERVING_VECTOR_REJECTION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPVR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPVR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lpvr_pkg.sv
// Shared constants for the vector rejection pipeline.
package lpvr_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    // Width of one partial-product slice in the wide multipliers.
    localparam int MUL_LIMB = 32;

endpackage

>>> rtl/length_preserving_vector_rejection.sv
// Top level: streaming 3-D vector rejection with length restore.
// Takes one (k, b) vector pair per cycle and returns b with its component along
// k removed, rescaled back to |b|: out = w |b| / |w| with w = (k x b) x k, which
// equals |k|^2 b - (k.b) k. All math is exact integer; each output component is
// rounded once to nearest (halves away from zero) and saturated. Zero k or zero
// b gives a zero vector; b parallel to k gives a zero vector with degenerate set.
// The pipeline is stages A and B for the cross product and |b|^2, then wide
// multipliers that form one MUL_LIMB x MUL_LIMB limb product per stage (2 stages
// for c * k, 9 for w^2, 12 for w^2 |b|^2), one stage each for w and |w|^2, then
// a restoring square-root/ratio recurrence of DATA_WIDTH stages, one result bit
// per stage, then the output register. Throughput is one transfer per cycle while
// the output is not stalled; the whole pipeline advances whenever the output
// register is empty or being taken, so a stall on the result side holds every
// stage in place.
module length_preserving_vector_rejection import lpvr_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_k_x,
    input  logic signed [DATA_WIDTH-1:0] s_k_y,
    input  logic signed [DATA_WIDTH-1:0] s_k_z,
    input  logic signed [DATA_WIDTH-1:0] s_b_x,
    input  logic signed [DATA_WIDTH-1:0] s_b_y,
    input  logic signed [DATA_WIDTH-1:0] s_b_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_out_x,
    output logic signed [DATA_WIDTH-1:0] m_out_y,
    output logic signed [DATA_WIDTH-1:0] m_out_z,
    output logic                         m_degenerate
);

`include "length_preserving_vector_rejection_macros.svh"

    localparam int DW  = DATA_WIDTH;
    localparam int CW  = 2 * DW + 1;  // signed cross product
    localparam int WW  = 3 * DW + 2;  // signed w component
    localparam int DDW = 6 * DW;      // |w|^2 and its squares
    localparam int EW  = 8 * DW;      // sqrt remainder
    localparam int FW  = 7 * DW + 2;  // signed T * D term
    localparam int TW  = 8 * DW + 4;  // trial remainder
    localparam int SW2 = 6 + 2 * DW + 3;
    localparam int SW3 = 3 + 2 * DW + 3;
    localparam int SW4 = DDW + 3 + 3;

    // flags carried down the pipe
    typedef struct packed {
        logic knz;  // k nonzero
        logic bnz;  // b nonzero
        logic cnz;  // k x b nonzero
    } flags_t;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------- stage A: raw products ----------------
    logic                 va_reg;
    logic signed [2*DW-1:0] pa_reg [9];
    logic signed [DW-1:0] ka_reg [3];
    logic                 knz_a_reg, bnz_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg[0] <= s_k_y * s_b_z;
            pa_reg[1] <= s_k_z * s_b_y;
            pa_reg[2] <= s_k_z * s_b_x;
            pa_reg[3] <= s_k_x * s_b_z;
            pa_reg[4] <= s_k_x * s_b_y;
            pa_reg[5] <= s_k_y * s_b_x;
            pa_reg[6] <= s_b_x * s_b_x;
            pa_reg[7] <= s_b_y * s_b_y;
            pa_reg[8] <= s_b_z * s_b_z;
            ka_reg[0] <= s_k_x;
            ka_reg[1] <= s_k_y;
            ka_reg[2] <= s_k_z;
            knz_a_reg <= (|s_k_x) || (|s_k_y) || (|s_k_z);
            bnz_a_reg <= (|s_b_x) || (|s_b_y) || (|s_b_z);
        end
    end

    // ---------------- stage B: cross product, |b|^2, magnitudes ----------------
    logic                 vb_reg;
    logic [2*DW-1:0]      cmag_b_reg [3];
    logic                 csgn_b_reg [3];
    logic [DW-1:0]        kmag_b_reg [3];
    logic                 ksgn_b_reg [3];
    logic [2*DW-1:0]      b2_b_reg;
    flags_t               flags_b_reg;

    logic signed [CW-1:0] c_vec [3];
    logic [2*DW+1:0]      b2_sum;

    always_comb begin
        c_vec[0] = CW'(pa_reg[0]) - CW'(pa_reg[1]);
        c_vec[1] = CW'(pa_reg[2]) - CW'(pa_reg[3]);
        c_vec[2] = CW'(pa_reg[4]) - CW'(pa_reg[5]);
        b2_sum   = (2*DW+2)'(unsigned'(pa_reg[6])) + (2*DW+2)'(unsigned'(pa_reg[7]))
                 + (2*DW+2)'(unsigned'(pa_reg[8]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                csgn_b_reg[i] <= c_vec[i][CW-1];
                cmag_b_reg[i] <= c_vec[i][CW-1] ? (2*DW)'(-c_vec[i]) : (2*DW)'(c_vec[i]);
                ksgn_b_reg[i] <= ka_reg[i][DW-1];
                kmag_b_reg[i] <= ka_reg[i][DW-1] ? DW'(-ka_reg[i]) : DW'(ka_reg[i]);
            end
            b2_b_reg        <= b2_sum[2*DW-1:0];
            flags_b_reg.knz <= knz_a_reg;
            flags_b_reg.bnz <= bnz_a_reg;
            flags_b_reg.cnz <= (|c_vec[0]) || (|c_vec[1]) || (|c_vec[2]);
        end
    end

    // ---------------- P2: the six c * k products ----------------
    // lane order: cy*kz, cz*ky, cz*kx, cx*kz, cx*ky, cy*kx
    logic [5:0][2*DW-1:0] m2_a;
    logic [5:0][DW-1:0]   m2_b;
    logic [5:0]           m2_sgn;
    logic [SW2-1:0]       m2_side_in, m2_side_out;
    logic [5:0][3*DW-1:0] m2_p;
    logic                 m2_valid;

    always_comb begin
        m2_a[0] = cmag_b_reg[1]; m2_b[0] = kmag_b_reg[2];
        m2_sgn[0] = csgn_b_reg[1] ^ ksgn_b_reg[2];
        m2_a[1] = cmag_b_reg[2]; m2_b[1] = kmag_b_reg[1];
        m2_sgn[1] = csgn_b_reg[2] ^ ksgn_b_reg[1];
        m2_a[2] = cmag_b_reg[2]; m2_b[2] = kmag_b_reg[0];
        m2_sgn[2] = csgn_b_reg[2] ^ ksgn_b_reg[0];
        m2_a[3] = cmag_b_reg[0]; m2_b[3] = kmag_b_reg[2];
        m2_sgn[3] = csgn_b_reg[0] ^ ksgn_b_reg[2];
        m2_a[4] = cmag_b_reg[0]; m2_b[4] = kmag_b_reg[1];
        m2_sgn[4] = csgn_b_reg[0] ^ ksgn_b_reg[1];
        m2_a[5] = cmag_b_reg[1]; m2_b[5] = kmag_b_reg[0];
        m2_sgn[5] = csgn_b_reg[1] ^ ksgn_b_reg[0];
        m2_side_in = {flags_b_reg, b2_b_reg, m2_sgn};
    end

    lpvr_mul #(.LANES(6), .AW(2*DW), .BW(DW), .SW(SW2)) u_mul_ck (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vb_reg),
        .a(m2_a), .b(m2_b), .side_in(m2_side_in),
        .out_valid(m2_valid), .p(m2_p), .side_out(m2_side_out)
    );

    // ---------------- stage C: w = c x k, magnitudes ----------------
    logic                 vc_reg;
    logic [3*DW-1:0]      wmag_c_reg [3];
    logic [2:0]           wsgn_c_reg;
    logic [2*DW-1:0]      b2_c_reg;
    flags_t               flags_c_reg;

    logic signed [WW-1:0] sp [6];
    logic signed [WW-1:0] w_vec [3];
    logic [5:0]           m2_sgn_o;

    always_comb begin
        m2_sgn_o = m2_side_out[5:0];
        for (int l = 0; l < 6; l++) begin
            sp[l] = m2_sgn_o[l] ? -$signed(WW'(m2_p[l])) : $signed(WW'(m2_p[l]));
        end
        for (int i = 0; i < 3; i++) begin
            w_vec[i] = sp[2*i] - sp[2*i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= m2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                wsgn_c_reg[i] <= w_vec[i][WW-1];
                wmag_c_reg[i] <= w_vec[i][WW-1] ? (3*DW)'(-w_vec[i]) : (3*DW)'(w_vec[i]);
            end
            b2_c_reg    <= m2_side_out[6 +: 2*DW];
            flags_c_reg <= m2_side_out[6+2*DW +: 3];
        end
    end

    // ---------------- P3: w_i^2 ----------------
    logic [2:0][3*DW-1:0] m3_a;
    logic [SW3-1:0]       m3_side_in, m3_side_out;
    logic [2:0][DDW-1:0]  m3_p;
    logic                 m3_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m3_a[i] = wmag_c_reg[i];
        end
        m3_side_in = {flags_c_reg, b2_c_reg, wsgn_c_reg};
    end

    lpvr_mul #(.LANES(3), .AW(3*DW), .BW(3*DW), .SW(SW3)) u_mul_sq (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vc_reg),
        .a(m3_a), .b(m3_a), .side_in(m3_side_in),
        .out_valid(m3_valid), .p(m3_p), .side_out(m3_side_out)
    );

    // ---------------- stage D: |w|^2 ----------------
    logic                 vd_reg;
    logic [2:0][DDW-1:0]  sq_d_reg;
    logic [DDW-1:0]       w2_d_reg;
    logic [2:0]           wsgn_d_reg;
    logic [2*DW-1:0]      b2_d_reg;
    flags_t               flags_d_reg;
    logic [DDW+1:0]       w2_sum;

    assign w2_sum = (DDW+2)'(m3_p[0]) + (DDW+2)'(m3_p[1]) + (DDW+2)'(m3_p[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= m3_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_d_reg    <= m3_p;
            w2_d_reg    <= w2_sum[DDW-1:0];
            wsgn_d_reg  <= m3_side_out[2:0];
            b2_d_reg    <= m3_side_out[3 +: 2*DW];
            flags_d_reg <= m3_side_out[3+2*DW +: 3];
        end
    end

    // ---------------- P4: N_i = w_i^2 |b|^2 ----------------
    logic [2:0][2*DW-1:0] m4_b;
    logic [SW4-1:0]       m4_side_in, m4_side_out;
    logic [2:0][EW-1:0]   m4_p;
    logic                 m4_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m4_b[i] = b2_d_reg;
        end
        m4_side_in = {flags_d_reg, wsgn_d_reg, w2_d_reg};
    end

    lpvr_mul #(.LANES(3), .AW(DDW), .BW(2*DW), .SW(SW4)) u_mul_nb (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vd_reg),
        .a(sq_d_reg), .b(m4_b), .side_in(m4_side_in),
        .out_valid(m4_valid), .p(m4_p), .side_out(m4_side_out)
    );

    // ---------------- square-root recurrence ----------------
    // Finds the largest m with (2m-1)^2 D <= 4N, one bit per stage, MSB first.
    // E = 4N + D - T^2 D and F = T D with T = 2m - 1 (E starts at 4N for T = -1),
    // so each trial is shifts and adds and a bit is taken when the trial is >= D.
    logic                 sv_reg    [DW];
    logic [EW-1:0]        se_reg    [DW][3];
    logic signed [FW-1:0] sf_reg    [DW][3];
    logic [DW-1:0]        sm_reg    [DW][3];
    logic [DDW-1:0]       sd_reg    [DW];
    logic [2:0]           ssgn_reg  [DW];
    flags_t               sflg_reg  [DW];

    logic                 sv_src    [DW];
    logic [EW-1:0]        se_src    [DW][3];
    logic signed [FW-1:0] sf_src    [DW][3];
    logic [DW-1:0]        sm_src    [DW][3];
    logic [DDW-1:0]       sd_src    [DW];
    logic [2:0]           ssgn_src  [DW];
    flags_t               sflg_src  [DW];

    logic [EW-1:0]        se_next   [DW][3];
    logic signed [FW-1:0] sf_next   [DW][3];
    logic [DW-1:0]        sm_next   [DW][3];

    genvar gj, gl;
    generate
        for (gj = 0; gj < DW; gj++) begin : g_sq_src
            if (gj == 0) begin : g_first
                assign sv_src[gj]   = m4_valid;
                assign sd_src[gj]   = m4_side_out[DDW-1:0];
                assign ssgn_src[gj] = m4_side_out[DDW +: 3];
                assign sflg_src[gj] = m4_side_out[DDW+3 +: 3];
                for (gl = 0; gl < 3; gl++) begin : g_lane
                    assign se_src[gj][gl] = m4_p[gl] << 2;
                    assign sf_src[gj][gl] = -$signed(FW'(m4_side_out[DDW-1:0]));
                    assign sm_src[gj][gl] = '0;
                end
            end else begin : g_rest
                assign sv_src[gj]   = sv_reg[gj-1];
                assign sd_src[gj]   = sd_reg[gj-1];
                assign ssgn_src[gj] = ssgn_reg[gj-1];
                assign sflg_src[gj] = sflg_reg[gj-1];
                for (gl = 0; gl < 3; gl++) begin : g_lane
                    assign se_src[gj][gl] = se_reg[gj-1][gl];
                    assign sf_src[gj][gl] = sf_reg[gj-1][gl];
                    assign sm_src[gj][gl] = sm_reg[gj-1][gl];
                end
            end
        end
    endgenerate

    always_comb begin
        logic signed [TW-1:0] e_ext;
        logic signed [TW-1:0] f_ext;
        logic signed [TW-1:0] d_ext;
        logic signed [TW-1:0] trial;
        logic signed [FW-1:0] d_f;
        int                   bit_pos;
        for (int j = 0; j < DW; j++) begin
            bit_pos = DW - 1 - j;
            for (int l = 0; l < 3; l++) begin
                e_ext = $signed(TW'(se_src[j][l]));
                f_ext = TW'(sf_src[j][l]);
                d_ext = $signed(TW'(sd_src[j]));
                d_f   = $signed(FW'(sd_src[j]));
                trial = e_ext - (f_ext <<< (bit_pos + 2)) - (d_ext <<< (2 * bit_pos + 2));
                if (trial >= d_ext) begin
                    se_next[j][l] = trial[EW-1:0];
                    sf_next[j][l] = sf_src[j][l] + (d_f <<< (bit_pos + 1));
                    sm_next[j][l] = sm_src[j][l] | (DW'(1) << bit_pos);
                end else begin
                    se_next[j][l] = se_src[j][l];
                    sf_next[j][l] = sf_src[j][l];
                    sm_next[j][l] = sm_src[j][l];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < DW; j++) begin
                sv_reg[j] <= 1'b0;
            end
        end else if (en) begin
            for (int j = 0; j < DW; j++) begin
                sv_reg[j] <= sv_src[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < DW; j++) begin
                sd_reg[j]   <= sd_src[j];
                ssgn_reg[j] <= ssgn_src[j];
                sflg_reg[j] <= sflg_src[j];
                for (int l = 0; l < 3; l++) begin
                    se_reg[j][l] <= se_next[j][l];
                    sf_reg[j][l] <= sf_next[j][l];
                    sm_reg[j][l] <= sm_next[j][l];
                end
            end
        end
    end

    // ---------------- output register: sign, saturation, special cases ----------------
    localparam logic [DW-1:0] HALF = DW'(1) << (DW - 1);

    logic                 m_valid_reg;
    logic [DW-1:0]        out_reg [3];
    logic                 deg_reg;
    logic [DW-1:0]        out_next [3];
    logic                 zero_out, deg_next;
    flags_t               fl_last;

    always_comb begin
        logic [DW-1:0] mv;
        fl_last  = sflg_reg[DW-1];
        deg_next = fl_last.knz && fl_last.bnz && !fl_last.cnz;
        zero_out = !fl_last.knz || !fl_last.bnz || !fl_last.cnz;
        for (int i = 0; i < 3; i++) begin
            mv = sm_reg[DW-1][i];
            if (ssgn_reg[DW-1][i]) begin
                if (mv > HALF) mv = HALF;
                out_next[i] = -mv;
            end else begin
                if (mv > HALF - DW'(1)) mv = HALF - DW'(1);
                out_next[i] = mv;
            end
            if (zero_out) out_next[i] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= sv_reg[DW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                out_reg[i] <= out_next[i];
            end
            deg_reg <= deg_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_x      = $signed(out_reg[0]);
    assign m_out_y      = $signed(out_reg[1]);
    assign m_out_z      = $signed(out_reg[2]);
    assign m_degenerate = deg_reg;

    // ---------------- assertions ----------------
    `LPVR_ASSERT_SAME(a_deg_zero, aclk, aresetn, m_valid && m_degenerate, (m_out_x == '0) && (m_out_y == '0) && (m_out_z == '0), "degenerate result with nonzero vector")
    `LPVR_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, va_reg, "accepted transfer did not enter the pipeline")
    `LPVR_ASSERT_NEXT(a_stall_freeze, aclk, aresetn, m_valid && !m_ready, $stable(va_reg) && $stable(sv_reg[DW-1]), "pipeline moved during output stall")

endmodule

>>> rtl/lpvr_mul.sv
// Pipelined multi-lane unsigned multiplier, one limb-by-limb product per stage, with sideband.
module lpvr_mul import lpvr_pkg::*; #(
    parameter int LANES = 1,
    parameter int AW    = 32,
    parameter int BW    = 32,
    parameter int SW    = 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [LANES-1:0][AW-1:0]       a,
    input  logic [LANES-1:0][BW-1:0]       b,
    input  logic [SW-1:0]                  side_in,
    output logic                           out_valid,
    output logic [LANES-1:0][AW+BW-1:0]    p,
    output logic [SW-1:0]                  side_out
);

    localparam int NA  = (AW + MUL_LIMB - 1) / MUL_LIMB;
    localparam int NB  = (BW + MUL_LIMB - 1) / MUL_LIMB;
    localparam int NST = NA * NB;
    localparam int APW = NA * MUL_LIMB;
    localparam int BPW = NB * MUL_LIMB;
    localparam int PW  = AW + BW;

    logic                         vld_reg  [NST];
    logic [LANES-1:0][APW-1:0]    a_reg    [NST];
    logic [LANES-1:0][BPW-1:0]    b_reg    [NST];
    logic [LANES-1:0][PW-1:0]     acc_reg  [NST];
    logic [SW-1:0]                side_reg [NST];

    logic                         vld_src  [NST];
    logic [LANES-1:0][APW-1:0]    a_src    [NST];
    logic [LANES-1:0][BPW-1:0]    b_src    [NST];
    logic [LANES-1:0][PW-1:0]     acc_src  [NST];
    logic [SW-1:0]                side_src [NST];
    logic [LANES-1:0][PW-1:0]     acc_next [NST];

    logic [LANES-1:0][APW-1:0]    a_pad;
    logic [LANES-1:0][BPW-1:0]    b_pad;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            a_pad[l] = APW'(a[l]);
            b_pad[l] = BPW'(b[l]);
        end
    end

    genvar gs, gl;
    generate
        for (gs = 0; gs < NST; gs++) begin : g_src
            if (gs == 0) begin : g_first
                assign vld_src[gs]  = in_valid;
                assign a_src[gs]    = a_pad;
                assign b_src[gs]    = b_pad;
                assign acc_src[gs]  = '0;
                assign side_src[gs] = side_in;
            end else begin : g_rest
                assign vld_src[gs]  = vld_reg[gs-1];
                assign a_src[gs]    = a_reg[gs-1];
                assign b_src[gs]    = b_reg[gs-1];
                assign acc_src[gs]  = acc_reg[gs-1];
                assign side_src[gs] = side_reg[gs-1];
            end
        end
    endgenerate

    // stage gs multiplies A limb (gs % NA) by B limb (gs / NA)
    generate
        for (gs = 0; gs < NST; gs++) begin : g_stage
            localparam int IA = gs % NA;
            localparam int IB = gs / NA;
            for (gl = 0; gl < LANES; gl++) begin : g_lane
                logic [2*MUL_LIMB-1:0] prod;
                assign prod = a_src[gs][gl][IA*MUL_LIMB +: MUL_LIMB]
                            * b_src[gs][gl][IB*MUL_LIMB +: MUL_LIMB];
                assign acc_next[gs][gl] = acc_src[gs][gl]
                                        + (PW'(prod) << ((IA + IB) * MUL_LIMB));
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NST; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (en) begin
            for (int s = 0; s < NST; s++) begin
                vld_reg[s] <= vld_src[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < NST; s++) begin
                a_reg[s]    <= a_src[s];
                b_reg[s]    <= b_src[s];
                acc_reg[s]  <= acc_next[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign p         = acc_reg[NST-1];
    assign side_out  = side_reg[NST-1];

endmodule

>>> dv/lpvr_checker.sv
// Transfer monitor, exact-arithmetic predictor and scoreboard for the vector rejection block.
`timescale 1ns / 1ps
module lpvr_checker import lpvr_pkg::*; #(
    parameter int DW = DATA_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic signed [DW-1:0] s_k_x,
    input  logic signed [DW-1:0] s_k_y,
    input  logic signed [DW-1:0] s_k_z,
    input  logic signed [DW-1:0] s_b_x,
    input  logic signed [DW-1:0] s_b_y,
    input  logic signed [DW-1:0] s_b_z,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic signed [DW-1:0] m_out_x,
    input  logic signed [DW-1:0] m_out_y,
    input  logic signed [DW-1:0] m_out_z,
    input  logic                 m_degenerate,
    output int                   errors,
    output int                   pending
);

    typedef logic [319:0]        wide_t;
    typedef logic signed [127:0] sw_t;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        logic                 degenerate;
    } rejected_t;

    rejected_t rejected_q[$];

    // largest m with (2m-1)^2 * den <= num
    function automatic logic [63:0] rounded_root(input wide_t num, input wide_t den);
        logic [63:0] m;
        logic [63:0] c;
        wide_t       t;
        m = '0;
        for (int bit_i = DW - 1; bit_i >= 0; bit_i--) begin
            c = m | (64'd1 << bit_i);
            t = wide_t'(2 * c - 1);
            if (t * t * den <= num) m = c;
        end
        return m;
    endfunction

    function automatic rejected_t reject_and_restore(
        input logic signed [DW-1:0] kx, ky, kz, bx, by, bz
    );
        sw_t         ks[3];
        sw_t         bs[3];
        sw_t         w[3];
        sw_t         k2, b2, dot;
        wide_t       wm[3];
        wide_t       w2, n;
        logic [63:0] m;
        logic [63:0] half;
        logic [DW-1:0] comp[3];
        rejected_t   r;
        ks[0] = kx; ks[1] = ky; ks[2] = kz;
        bs[0] = bx; bs[1] = by; bs[2] = bz;
        half = 64'd1 << (DW - 1);
        r = '0;
        k2 = 0; b2 = 0; dot = 0;
        for (int i = 0; i < 3; i++) begin
            k2 += ks[i] * ks[i];
            b2 += bs[i] * bs[i];
            dot += ks[i] * bs[i];
        end
        if (k2 == 0 || b2 == 0) return r;
        w2 = '0;
        for (int i = 0; i < 3; i++) begin
            w[i] = k2 * bs[i] - dot * ks[i];
            wm[i] = (w[i] < 0) ? wide_t'(-w[i]) : wide_t'(w[i]);
            w2 += wm[i] * wm[i];
        end
        if (w2 == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            n = wm[i] * wm[i] * wide_t'(b2) * wide_t'(4);
            m = rounded_root(n, w2);
            if (w[i] < 0) begin
                if (m > half) m = half;
                comp[i] = DW'(-m);
            end else begin
                if (m > half - 1) m = half - 1;
                comp[i] = DW'(m);
            end
        end
        r.x = comp[0]; r.y = comp[1]; r.z = comp[2];
        return r;
    endfunction

    initial begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        rejected_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                rejected_q.push_back(reject_and_restore(s_k_x, s_k_y, s_k_z,
                                                        s_b_x, s_b_y, s_b_z));
            if (m_valid && m_ready) begin
                if (rejected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected result %h %h %h deg=%b",
                                 m_out_x, m_out_y, m_out_z, m_degenerate);
                end else begin
                    want = rejected_q.pop_front();
                    if (want.x !== m_out_x || want.y !== m_out_y ||
                        want.z !== m_out_z || want.degenerate !== m_degenerate) begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: expected %h %h %h deg=%b, got %h %h %h deg=%b",
                                     want.x, want.y, want.z, want.degenerate,
                                     m_out_x, m_out_y, m_out_z, m_degenerate);
                    end
                end
            end
            pending = rejected_q.size();
        end
    end

endmodule

>>> dv/tb_length_preserving_vector_rejection.sv
// Stimulus, reset, watchdog and verdict for the vector rejection block.
`timescale 1ns / 1ps
module tb_length_preserving_vector_rejection;
    import lpvr_pkg::*;

    localparam int DW          = DATA_WIDTH_DEF;
    localparam int RANDOM_N    = 1350;
    localparam int STALL_LIMIT = 5000;   // cycles with no transfer on either side
    localparam int HOLD_START  = 800;    // receiver hold-off window, in receiver cycles
    localparam int HOLD_LEN    = 300;
    localparam int DRAIN_WAIT  = 100;    // extra wait after the scoreboard empties

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [DW-1:0] s_k_x, s_k_y, s_k_z, s_b_x, s_b_y, s_b_z;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [DW-1:0] m_out_x, m_out_y, m_out_z;
    logic                 m_degenerate;
    int                   errors;
    int                   pending;
    int                   quiet_cycles;
    bit                   calm;          // no idling on either side while set

    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    length_preserving_vector_rejection #(.DATA_WIDTH(DW)) dut (.*);

    lpvr_checker #(.DW(DW)) checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random backpressure, one long hold-off, a calm stretch.
    initial begin
        int rx_cycle;
        rx_cycle = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            rx_cycle++;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                m_ready <= 1'b0;
            else if (calm)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(99) >= 12);
        end
    end

    // Watchdog: ends the run when transfers stop.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // One input transfer, with an optional random gap before it.
    task automatic send_pair(input logic signed [DW-1:0] kx, ky, kz, bx, by, bz);
        if (!calm && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 50);
        end
        s_valid <= 1'b1;
        s_k_x <= kx; s_k_y <= ky; s_k_z <= kz;
        s_b_x <= bx; s_b_y <= by; s_b_z <= bz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic signed [DW-1:0] pick_edge();
        case ($urandom_range(4))
            0: return MAXV;
            1: return MINV;
            2: return 0;
            3: return 1;
            default: return -1;
        endcase
    endfunction

    function automatic logic signed [DW-1:0] pick_small();
        return $signed($urandom_range(2000)) - 1000;
    endfunction

    function automatic logic signed [DW-1:0] pick_scaled();
        return $signed($urandom()) >>> $urandom_range(DW - 1);
    endfunction

    // Mostly structured vector pairs: small, parallel, edge values, zeros, scaled.
    task automatic send_random_pair();
        logic signed [DW-1:0] k[3];
        logic signed [DW-1:0] b[3];
        int scale;
        case ($urandom_range(9))
            0, 1, 2: foreach (k[i]) begin k[i] = $urandom(); b[i] = $urandom(); end
            3, 4:    foreach (k[i]) begin k[i] = pick_small(); b[i] = pick_small(); end
            5: begin
                // b a multiple of k: parallel or zero
                scale = $signed($urandom_range(6)) - 3;
                foreach (k[i]) begin
                    k[i] = $signed($urandom()) >>> $urandom_range(4, DW - 1);
                    b[i] = k[i] * scale;
                end
            end
            6: foreach (k[i]) begin k[i] = pick_edge(); b[i] = pick_edge(); end
            7: begin
                foreach (k[i]) begin k[i] = $urandom(); b[i] = $urandom(); end
                if ($urandom_range(1)) k = '{0, 0, 0}; else b = '{0, 0, 0};
            end
            default: foreach (k[i]) begin k[i] = pick_scaled(); b[i] = pick_scaled(); end
        endcase
        send_pair(k[0], k[1], k[2], b[0], b[1], b[2]);
    endtask

    initial begin
        calm    = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_k_x <= '0; s_k_y <= '0; s_k_z <= '0;
        s_b_x <= '0; s_b_y <= '0; s_b_z <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero inputs, parallel cases, extremes, saturation, rounding.
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 5, -7, 9);
        send_pair(3, 4, 5, 0, 0, 0);
        send_pair(1, 2, 3, 1, 2, 3);
        send_pair(1, 2, 3, -2, -4, -6);
        send_pair(MINV, MINV, MINV, MAXV, MAXV, MAXV);
        send_pair(MINV, MINV, MINV, MINV, MINV, MINV);
        send_pair(MAXV, 0, 0, 0, MAXV, 0);
        send_pair(1, 0, 0, MINV, MINV, MINV);
        send_pair(1, 0, 0, MAXV, MAXV, MAXV);
        send_pair(0, 0, 1, MAXV, MINV, MAXV);
        send_pair(MINV, 0, 0, MAXV, MINV, MINV);
        send_pair(1, 1, 0, 1, 0, 0);
        send_pair(1, 1, 1, 1, 0, 0);
        send_pair(1, 0, 0, 1, 1, 0);
        send_pair(1, 2, 0, 3, 1, 0);
        send_pair(-1, -1, -1, 2, -1, 0);
        send_pair(MAXV, MAXV, MAXV, MAXV, MAXV, MINV);
        send_pair(32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 0);
        send_pair(MAXV, 1, -1, 1, MAXV, MINV);
        send_pair(MINV, MAXV, 0, 1, 1, 1);

        for (int n = 0; n < RANDOM_N; n++) begin
            calm = (n >= 400 && n < 600);
            if (n == 900) begin
                // sender pause: let the pipeline run dry
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending != 0);
            end
            send_random_pair();
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/lpvr_pkg.sv
rtl/lpvr_mul.sv
rtl/length_preserving_vector_rejection.sv
dv/lpvr_checker.sv
dv/tb_length_preserving_vector_rejection.sv
